### design/pattern_match_clear_stream_macros.svh
// ============================================================================
// Assertion macros for the pattern match and clear stream block
// Short forms of the concurrent assertions used inside the design modules.
// Each macro expects signals named clk and rst_n in the calling module.
// ============================================================================
`ifndef PATTERN_MATCH_CLEAR_STREAM_MACROS_SVH
`define PATTERN_MATCH_CLEAR_STREAM_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define PMC_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// A condition that implies another one in the same cycle.
`define PMC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies another one in the next cycle.
`define PMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pmc_pkg.sv
// ============================================================================
// pmc_pkg
// Shared types and constants of the pattern match and clear stream block.
// ============================================================================
`default_nettype none

package pmc_pkg;

  // Window slots in the datapath and pattern bytes held in the registers.
  localparam int WIN_SLOTS         = 16;
  localparam int PAT_BYTES         = 16;
  localparam int MAX_PATTERN_BYTES = 16;

  // Field widths.
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 5;
  localparam int COUNT_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR    = 2'd3;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [LEN_W-1:0]   len_t;

  // Settings that the window logic works with.
  typedef struct packed {
    logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
    len_t                             len;        // effective length, 1 up to the cap
    byte_t                            clear_val;
    logic                             restart;    // length written: start a new stream
  } cfg_t;

  // One emitted byte from the window toward the output register.
  typedef struct packed {
    logic   valid;
    byte_t  data;
    logic   last;
    count_t count;
  } emit_t;

endpackage

`default_nettype wire

### design/pmc_cfg.sv
// ============================================================================
// pmc_cfg
// Configuration registers with the effective pattern length.
// ============================================================================
`default_nettype none

module pmc_cfg #(
  parameter int MAX_PATTERN_BYTES = pmc_pkg::MAX_PATTERN_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [pmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pmc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pmc_pkg::cfg_t                        cfg
);

  localparam int LEN_CAP = (MAX_PATTERN_BYTES < pmc_pkg::WIN_SLOTS) ?
                           MAX_PATTERN_BYTES : pmc_pkg::WIN_SLOTS;

  logic [pmc_pkg::CFG_DATA_W-1:0] pat_low_r, pat_low_nxt;
  logic [pmc_pkg::CFG_DATA_W-1:0] pat_high_r, pat_high_nxt;
  pmc_pkg::len_t                  len_raw_r, len_raw_nxt;
  pmc_pkg::byte_t                 clear_r, clear_nxt;
  logic                           restart;
  pmc_pkg::len_t                  len_eff;

  // Register write decode.
  always_comb begin
    pat_low_nxt  = pat_low_r;
    pat_high_nxt = pat_high_r;
    len_raw_nxt  = len_raw_r;
    clear_nxt    = clear_r;
    restart      = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        pmc_pkg::REG_PAT_LOW:  pat_low_nxt  = cfg_wdata;
        pmc_pkg::REG_PAT_HIGH: pat_high_nxt = cfg_wdata;
        pmc_pkg::REG_PAT_LEN: begin
          len_raw_nxt = cfg_wdata[pmc_pkg::LEN_W-1:0];
          restart     = 1'b1;
        end
        pmc_pkg::REG_CLEAR:    clear_nxt    = cfg_wdata[pmc_pkg::BYTE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      len_raw_r  <= pmc_pkg::LEN_W'(1);
      clear_r    <= '0;
    end else begin
      pat_low_r  <= pat_low_nxt;
      pat_high_r <= pat_high_nxt;
      len_raw_r  <= len_raw_nxt;
      clear_r    <= clear_nxt;
    end
  end

  // A length of zero acts as one; a length above the cap acts as the cap.
  always_comb begin
    priority if (len_raw_r == '0) begin
      len_eff = pmc_pkg::LEN_W'(1);
    end else if (len_raw_r > pmc_pkg::LEN_W'(LEN_CAP)) begin
      len_eff = pmc_pkg::LEN_W'(LEN_CAP);
    end else begin
      len_eff = len_raw_r;
    end
  end

  // Pattern byte i sits in bits 8i of the low word, then of the high word.
  assign cfg.pattern   = {pat_high_r, pat_low_r};
  assign cfg.len       = len_eff;
  assign cfg.clear_val = clear_r;
  assign cfg.restart   = restart;

endmodule

`default_nettype wire

### design/pmc_window.sv
// ============================================================================
// pmc_window
// Byte window with parallel pattern compare, match marking and end flush.
// ============================================================================
`default_nettype none

module pmc_window #(
  parameter int MAX_PATTERN_BYTES = pmc_pkg::MAX_PATTERN_BYTES
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pmc_pkg::cfg_t  cfg,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire pmc_pkg::byte_t in_byte,
  input  wire logic           in_final,
  input  wire logic           can_load,
  output pmc_pkg::emit_t      emit
);

  `include "pattern_match_clear_stream_macros.svh"

  localparam int LEN_CAP = (MAX_PATTERN_BYTES < pmc_pkg::WIN_SLOTS) ?
                           MAX_PATTERN_BYTES : pmc_pkg::WIN_SLOTS;
  localparam int FW      = $clog2(LEN_CAP + 1);
  localparam int LW      = pmc_pkg::LEN_W;

  typedef logic [LEN_CAP-1:0][pmc_pkg::BYTE_W-1:0] win_t;

  win_t                 win_r, win_nxt;
  logic [LEN_CAP-1:0]   mark_r, mark_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  pmc_pkg::count_t      count_r, count_nxt;
  logic                 flush_r, flush_nxt;

  logic [LW-1:0]        fill5;
  logic [LW-1:0]        fill_app5;
  logic [LW-1:0]        len_m1;
  win_t                 win_app, win_app_sh, win_r_sh;
  logic [LEN_CAP-1:0]   mark_app, mark_hit, mark_hit_sh, mark_r_sh;
  logic                 full;
  logic                 hit;
  logic                 in_acc;
  pmc_pkg::count_t      count_inc;

  assign fill5     = LW'(fill_r);
  assign fill_app5 = fill5 + LW'(1);
  assign len_m1    = cfg.len - LW'(1);
  assign full      = (fill_app5 == cfg.len);

  // No new item while the window drains at the end of a stream.
  assign in_tready = can_load && !flush_r;
  assign in_acc    = in_tvalid && in_tready;

  // Append the new byte behind the buffered ones, then compare the window.
  always_comb begin
    win_app  = win_r;
    mark_app = mark_r;
    hit      = full;
    for (int i = 0; i < LEN_CAP; i++) begin
      if (fill5 == LW'(i)) begin
        win_app[i]  = in_byte;
        mark_app[i] = 1'b0;
      end
    end
    for (int i = 0; i < LEN_CAP; i++) begin
      if (LW'(i) < cfg.len) begin
        if (mark_app[i] || (win_app[i] != cfg.pattern[i])) begin
          hit = 1'b0;
        end
      end
    end
    mark_hit = mark_app;
    for (int i = 0; i < LEN_CAP; i++) begin
      if (hit && (LW'(i) < cfg.len)) begin
        mark_hit[i] = 1'b1;
      end
    end
  end

  // Saturating match counter.
  assign count_inc = (hit && (count_r != pmc_pkg::COUNT_MAX)) ?
                     count_r + pmc_pkg::COUNT_W'(1) : count_r;

  // The oldest byte leaves at slot 0, the rest move down one slot.
  always_comb begin
    win_app_sh  = '0;
    mark_hit_sh = '0;
    win_r_sh    = '0;
    mark_r_sh   = '0;
    for (int i = 0; i < LEN_CAP - 1; i++) begin
      win_app_sh[i]  = win_app[i+1];
      mark_hit_sh[i] = mark_hit[i+1];
      win_r_sh[i]    = win_r[i+1];
      mark_r_sh[i]   = mark_r[i+1];
    end
  end

  // Next state and emitted byte.
  always_comb begin
    win_nxt   = win_r;
    mark_nxt  = mark_r;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    flush_nxt = flush_r;
    emit      = '0;
    priority if (cfg.restart) begin
      mark_nxt  = '0;
      fill_nxt  = '0;
      count_nxt = '0;
      flush_nxt = 1'b0;
    end else if (flush_r) begin
      if (can_load) begin
        emit.valid = 1'b1;
        emit.data  = mark_r[0] ? cfg.clear_val : win_r[0];
        emit.last  = (fill5 == LW'(1));
        emit.count = count_r;
        win_nxt    = win_r_sh;
        mark_nxt   = mark_r_sh;
        fill_nxt   = fill_r - FW'(1);
        if (fill5 == LW'(1)) begin
          mark_nxt  = '0;
          count_nxt = '0;
          flush_nxt = 1'b0;
        end
      end
    end else if (in_acc) begin
      count_nxt = count_inc;
      if (full) begin
        emit.valid = 1'b1;
        emit.data  = mark_hit[0] ? cfg.clear_val : win_app[0];
        emit.last  = in_final && (cfg.len == LW'(1));
        emit.count = count_inc;
        win_nxt    = win_app_sh;
        mark_nxt   = mark_hit_sh;
        fill_nxt   = len_m1[FW-1:0];
      end else begin
        win_nxt    = win_app;
        mark_nxt   = mark_app;
        fill_nxt   = fill_app5[FW-1:0];
      end
      if (in_final) begin
        if (full && (len_m1 == '0)) begin
          mark_nxt  = '0;
          fill_nxt  = '0;
          count_nxt = '0;
        end else begin
          flush_nxt = 1'b1;
        end
      end
    end
  end

  // Window bytes are payload; marks, fill and count are control.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r  <= '0;
      fill_r  <= '0;
      count_r <= '0;
      flush_r <= 1'b0;
    end else begin
      mark_r  <= mark_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
      flush_r <= flush_nxt;
    end
  end

  // Between items the window always holds fewer bytes than the pattern.
  `PMC_ASSERT_HOLDS(a_fill_below_len, flush_r || (fill5 < cfg.len), "window overfilled")
  // A flush never runs on an empty window.
  `PMC_ASSERT_IMPLIES(a_flush_not_empty, flush_r, fill5 != '0, "flush with empty window")
  // The input is held off for the whole flush.
  `PMC_ASSERT_IMPLIES(a_no_input_in_flush, flush_r, !in_tready, "input taken during flush")
  // The last flushed byte starts a fresh stream.
  `PMC_ASSERT_NEXT(a_flush_end_clears, flush_r && can_load && (fill5 == LW'(1)),
                   !flush_r && (fill_r == '0) && (count_r == '0), "stream not cleared")

endmodule

`default_nettype wire

### design/pmc_out_stage.sv
// ============================================================================
// pmc_out_stage
// Output register toward the result channel.
// ============================================================================
`default_nettype none

module pmc_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pmc_pkg::emit_t emit,
  output logic                can_load,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output pmc_pkg::byte_t      out_byte,
  output logic                out_last,
  output pmc_pkg::count_t     out_count
);

  `include "pattern_match_clear_stream_macros.svh"

  logic            valid_r, valid_nxt;
  pmc_pkg::byte_t  byte_r;
  logic            last_r;
  pmc_pkg::count_t count_r;

  // The register takes a new item when empty or when its item leaves now.
  assign can_load  = !valid_r || out_tready;
  assign valid_nxt = emit.valid || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads only with a new item.
  always_ff @(posedge clk) begin
    if (emit.valid) begin
      byte_r  <= emit.data;
      last_r  <= emit.last;
      count_r <= emit.count;
    end
  end

  assign out_tvalid = valid_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_count  = count_r;

  // The window never hands over an item while a stalled one still waits.
  `PMC_ASSERT_IMPLIES(a_emit_into_free, emit.valid, !valid_r || out_tready,
                      "item overwrites a waiting result")

endmodule

`default_nettype wire

### design/pattern_match_clear_stream.sv
// ============================================================================
// pattern_match_clear_stream
// Streaming pattern match: clears every leftmost non-overlapping match.
// ============================================================================
// The block takes one byte per cycle while the output can load and no flush
// runs, and shows each byte on the output in the cycle after the byte that
// pushes it out of the pattern-long window; the whole window is compared with
// the pattern in the cycle the item arrives. A byte marked as the last of its
// stream starts a flush: the bytes still in the window leave one per cycle
// through the single output register unless stalled, and the input is held
// off until the flush ends. Writing the pattern length drops the window and
// starts a new stream; the other registers take effect on the next item.
// ============================================================================
`default_nettype none

module pattern_match_clear_stream #(
  parameter int MAX_PATTERN_BYTES = pmc_pkg::MAX_PATTERN_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  wire logic                            in_tlast,   // final_byte
  // Result channel.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [23:0]                          out_tdata,  // [7:0] out_byte, [23:8] match_count
  output logic                                 out_tlast,  // out_last
  // Configuration write port.
  input  wire logic                            cfg_wr_en,
  input  wire logic [pmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pmc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pmc_pkg::cfg_t   cfg;
  pmc_pkg::emit_t  emit;
  logic            can_load;
  pmc_pkg::byte_t  res_byte;
  pmc_pkg::count_t res_count;

  pmc_cfg #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pmc_window #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_final  (in_tlast),
    .can_load  (can_load),
    .emit      (emit)
  );

  pmc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (res_byte),
    .out_last   (out_tlast),
    .out_count  (res_count)
  );

  assign out_tdata = {res_count, res_byte};

endmodule

`default_nettype wire
